@@ rtl/wpp_pkg.sv @@
package wpp_pkg;

  // Transaction kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_START = 2'd1,
    K_CLEAR = 2'd2,
    K_TICK  = 2'd3
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NO_SLOT  = 3'd3,
    ST_RUNNING  = 3'd4,
    ST_NOTHING  = 3'd5,
    ST_BAD_SEQ  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_MANUAL = 2'd2
  } adc_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_HEAD2,
    S_FETCH
  } back_state_t;

  // One classified transaction, as handed from the front to the back.
  typedef struct packed {
    op_kind_t     kind;
    logic         first;
    logic         too_long;
    logic         empty_len;
    logic [15:0]  idx;
    logic [15:0]  len;
    logic [47:0]  pos;
    logic         sync;
    logic [31:0]  period;
  } wpp_item_t;

endpackage

@@ rtl/wpp_ram.sv @@
module wpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/wpp_front.sv @@
module wpp_front
  import wpp_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] pos_z,
  input  logic [15:0] point_index,
  input  logic [15:0] path_length,
  input  logic        manual_trig,
  input  logic [31:0] period_ticks,
  output logic        item_valid,
  output wpp_item_t   item,
  input  logic        item_pop
);

  wpp_item_t  cls;
  wpp_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // Classify the incoming transaction: checks that need no block state.
  always_comb begin
    cls.kind      = op_kind_t'(kind);
    cls.first     = (point_index == 16'd0);
    cls.too_long  = (path_length > 16'(MAX_POINTS));
    cls.empty_len = (path_length == 16'd0);
    cls.idx       = point_index;
    cls.len       = path_length;
    cls.pos       = {pos_z, pos_y, pos_x};
    cls.sync      = manual_trig;
    cls.period    = (period_ticks == 32'd0) ? 32'd1 : period_ticks;
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, item_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/wpp_back.sv @@
module wpp_back
  import wpp_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  wpp_item_t   item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        position_valid,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [15:0] out_z,
  output logic        adc_strobe,
  output logic        running,
  output logic [1:0]  trigger_mode,
  output logic        feedback_disable
);

  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int LEN_W   = $clog2(MAX_POINTS + 1);
  localparam int PIDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int QW      = SLOT_W + LEN_W;
  localparam int P_DEPTH = SLOT_COUNT * MAX_POINTS;
  localparam int PA_W    = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;

  back_state_t           state, state_next;
  logic [SLOT_COUNT-1:0] busy, busy_next;
  logic [SLOT_W-1:0]     q_head, q_head_next;
  logic [CNT_W-1:0]      q_count, q_count_next;
  logic                  load_open, load_open_next;
  logic [SLOT_W-1:0]     load_slot, load_slot_next;
  logic [LEN_W-1:0]      load_count, load_count_next;
  logic [LEN_W-1:0]      load_expected, load_expected_next;
  logic                  play_active, play_active_next;
  logic [LEN_W-1:0]      play_point, play_point_next;
  logic [31:0]           tick_counter, tick_counter_next;
  logic [31:0]           tick_period, tick_period_next;
  adc_mode_t             adc_mode, adc_mode_next;

  logic                  can_write;
  logic                  out_we;
  status_t               res_status;
  logic                  res_pvalid;
  logic                  res_strobe;
  logic                  res_fb;

  logic [SLOT_COUNT-1:0] clr_mask;
  logic [SLOT_COUNT-1:0] busy_eff;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_slot;

  logic [SLOT_W:0]       tail_sum;
  logic [SLOT_W-1:0]     q_tail;
  logic [SLOT_W-1:0]     head_adv;
  logic [LEN_W-1:0]      len_w;
  logic [LEN_W-1:0]      load_count_inc;

  logic                  q_we;
  logic [QW-1:0]         q_wdata;
  logic                  q_re;
  logic [SLOT_W-1:0]     q_raddr;
  logic [QW-1:0]         q_rdata;
  logic [SLOT_W-1:0]     q_slot;
  logic [LEN_W-1:0]      q_len;

  logic                  p_we;
  logic                  p_re;
  logic [SLOT_W-1:0]     p_slot_sel;
  logic [PIDX_W-1:0]     p_pidx_sel;
  logic [PA_W-1:0]       p_addr;
  logic [47:0]           p_rdata;

  logic [47:0]           o_pos;

  assign can_write = !out_valid || out_ready;

  // Lowest free slot, seeing the slot of an open load as already released.
  assign clr_mask = load_open ? (SLOT_COUNT'(1) << load_slot) : '0;
  assign busy_eff = busy & ~clr_mask;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_eff[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign tail_sum = (SLOT_W+1)'(q_head) + (SLOT_W+1)'(q_count);
  assign q_tail   = (tail_sum >= (SLOT_W+1)'(SLOT_COUNT)) ?
                    SLOT_W'(tail_sum - (SLOT_W+1)'(SLOT_COUNT)) : SLOT_W'(tail_sum);
  assign head_adv = (q_head == SLOT_W'(SLOT_COUNT - 1)) ? '0 : q_head + 1'b1;

  assign len_w          = LEN_W'(item.len);
  assign load_count_inc = load_count + 1'b1;

  assign q_slot = q_rdata[QW-1:LEN_W];
  assign q_len  = q_rdata[LEN_W-1:0];

  assign p_addr = PA_W'(p_slot_sel) * PA_W'(MAX_POINTS) + PA_W'(p_pidx_sel);

  always_comb begin
    state_next         = state;
    busy_next          = busy;
    q_head_next        = q_head;
    q_count_next       = q_count;
    load_open_next     = load_open;
    load_slot_next     = load_slot;
    load_count_next    = load_count;
    load_expected_next = load_expected;
    play_active_next   = play_active;
    play_point_next    = play_point;
    tick_counter_next  = tick_counter;
    tick_period_next   = tick_period;
    adc_mode_next      = adc_mode;
    item_pop           = 1'b0;
    out_we             = 1'b0;
    res_status         = ST_OK;
    res_pvalid         = 1'b0;
    res_strobe         = 1'b0;
    res_fb             = 1'b0;
    q_we               = 1'b0;
    q_wdata            = '0;
    q_re               = 1'b0;
    q_raddr            = q_head;
    p_we               = 1'b0;
    p_re               = 1'b0;
    p_slot_sel         = q_slot;
    p_pidx_sel         = play_point[PIDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (item_valid && can_write) begin
          item_pop = 1'b1;
          out_we   = 1'b1;
          case (item.kind)
            K_LOAD: begin
              if (item.first) begin
                if (load_open) begin
                  busy_next[load_slot] = 1'b0;
                end
                load_open_next = 1'b0;
                if (item.too_long) begin
                  res_status = ST_TOO_LONG;
                end else if (item.empty_len) begin
                  res_status = ST_EMPTY;
                end else if (!free_found) begin
                  res_status = ST_NO_SLOT;
                end else begin
                  busy_next[free_slot] = 1'b1;
                  load_slot_next       = free_slot;
                  load_expected_next   = len_w;
                  load_count_next      = LEN_W'(1);
                  p_we                 = 1'b1;
                  p_slot_sel           = free_slot;
                  p_pidx_sel           = '0;
                  if (len_w == LEN_W'(1)) begin
                    q_we         = 1'b1;
                    q_wdata      = {free_slot, LEN_W'(1)};
                    q_count_next = q_count + 1'b1;
                  end else begin
                    load_open_next = 1'b1;
                  end
                end
              end else if (!load_open || (item.idx != 16'(load_count))) begin
                res_status = ST_BAD_SEQ;
              end else begin
                p_we            = 1'b1;
                p_slot_sel      = load_slot;
                p_pidx_sel      = item.idx[PIDX_W-1:0];
                load_count_next = load_count_inc;
                if (load_count_inc >= load_expected) begin
                  q_we           = 1'b1;
                  q_wdata        = {load_slot, load_count_inc};
                  q_count_next   = q_count + 1'b1;
                  load_open_next = 1'b0;
                end
              end
            end
            K_START: begin
              if (play_active) begin
                res_status = ST_RUNNING;
              end else if (q_count == '0) begin
                res_status = ST_NOTHING;
              end else begin
                res_fb            = 1'b1;
                adc_mode_next     = item.sync ? MODE_MANUAL : MODE_AUTO;
                play_point_next   = '0;
                play_active_next  = 1'b1;
                tick_period_next  = item.period;
                tick_counter_next = '0;
              end
            end
            K_CLEAR: begin
              busy_next         = '0;
              q_head_next       = '0;
              q_count_next      = '0;
              load_open_next    = 1'b0;
              play_active_next  = 1'b0;
              play_point_next   = '0;
              tick_counter_next = '0;
              adc_mode_next     = MODE_OFF;
            end
            K_TICK: begin
              if (play_active) begin
                if (({1'b0, tick_counter} + 33'd1) >= {1'b0, tick_period}) begin
                  tick_counter_next = '0;
                  q_re              = 1'b1;
                  out_we            = 1'b0;
                  state_next        = S_HEAD;
                end else begin
                  tick_counter_next = tick_counter + 32'd1;
                end
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      S_HEAD: begin
        if (play_point >= q_len) begin
          if (q_count == CNT_W'(1)) begin
            if (can_write) begin
              busy_next[q_slot] = 1'b0;
              q_head_next       = head_adv;
              q_count_next      = '0;
              play_point_next   = '0;
              play_active_next  = 1'b0;
              adc_mode_next     = MODE_OFF;
              out_we            = 1'b1;
              state_next        = S_IDLE;
            end
          end else begin
            busy_next[q_slot] = 1'b0;
            q_head_next       = head_adv;
            q_count_next      = q_count - 1'b1;
            play_point_next   = '0;
            q_re              = 1'b1;
            q_raddr           = head_adv;
            state_next        = S_HEAD2;
          end
        end else begin
          p_re       = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_HEAD2: begin
        p_re       = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        if (can_write) begin
          out_we          = 1'b1;
          res_pvalid      = 1'b1;
          res_strobe      = 1'b1;
          play_point_next = play_point + 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= '0;
      q_head        <= '0;
      q_count       <= '0;
      load_open     <= 1'b0;
      load_slot     <= '0;
      load_count    <= '0;
      load_expected <= '0;
      play_active   <= 1'b0;
      play_point    <= '0;
      tick_counter  <= '0;
      tick_period   <= 32'd1;
      adc_mode      <= MODE_OFF;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      busy          <= busy_next;
      q_head        <= q_head_next;
      q_count       <= q_count_next;
      load_open     <= load_open_next;
      load_slot     <= load_slot_next;
      load_count    <= load_count_next;
      load_expected <= load_expected_next;
      play_active   <= play_active_next;
      play_point    <= play_point_next;
      tick_counter  <= tick_counter_next;
      tick_period   <= tick_period_next;
      adc_mode      <= adc_mode_next;
      if (out_we) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      status           <= res_status;
      position_valid   <= res_pvalid;
      o_pos            <= res_pvalid ? p_rdata : 48'd0;
      adc_strobe       <= res_strobe;
      running          <= play_active_next;
      trigger_mode     <= adc_mode_next;
      feedback_disable <= res_fb;
    end
  end

  assign out_x = o_pos[15:0];
  assign out_y = o_pos[31:16];
  assign out_z = o_pos[47:32];

  wpp_ram #(
    .WIDTH (QW),
    .DEPTH (SLOT_COUNT)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_tail),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  wpp_ram #(
    .WIDTH (48),
    .DEPTH (P_DEPTH)
  ) u_points (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_addr),
    .wdata (item.pos),
    .re    (p_re),
    .raddr (p_addr),
    .rdata (p_rdata)
  );

endmodule

@@ rtl/waypoint_path_player.sv @@
// Order: each transaction is parked in the front queue, then executed from S_IDLE into the
// result register. A tick that fires also passes S_HEAD (play queue read) and S_FETCH (point
// read); a finished path retiring while another waits adds S_HEAD2, and the last path retiring
// stops playback straight from S_HEAD. Throughput: one transaction per cycle while the result
// register is not stalled, except firing ticks, which hold the executor for those states.
// Reset clears all control state at once; point memory and queue contents are left as they are.
module waypoint_path_player
  import wpp_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] pos_z,
  input  logic [15:0] point_index,
  input  logic [15:0] path_length,
  input  logic        manual_trig,
  input  logic [31:0] period_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        position_valid,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [15:0] out_z,
  output logic        adc_strobe,
  output logic        running,
  output logic [1:0]  trigger_mode,
  output logic        feedback_disable
);

  // The front classifies each transaction (first point, length checks, period of zero
  // taken as one) and parks it in a two-entry queue, so input keeps flowing while the
  // back is busy with a firing tick or its result register is stalled.
  wpp_item_t item;
  logic      item_valid;
  logic      item_pop;

  wpp_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .point_index  (point_index),
    .path_length  (path_length),
    .manual_trig  (manual_trig),
    .period_ticks (period_ticks),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  // The back owns the slot pool, the play queue and the point memory. Path lengths
  // travel in the play queue entries next to their slot numbers, so the head path's
  // length comes out of the same queue read that names its slot. Each result goes
  // through an output register, which holds it while the consumer stalls.
  wpp_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .position_valid   (position_valid),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .adc_strobe       (adc_strobe),
    .running          (running),
    .trigger_mode     (trigger_mode),
    .feedback_disable (feedback_disable)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import wpp_pkg::*;

  // Size of the slot pool and of one path, as configured on the instance.
  localparam int SLOTS = 8;
  localparam int PTS = 256;
  // Cycles without any transaction on either channel before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Clock edges waited after the last phase before the final verdict.
  localparam int TAIL_CYCLES = 16;

  // One input transaction, with every field carried even when the kind ignores it.
  typedef struct {
    op_kind_t    kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] idx;
    logic [15:0] len;
    logic        sync;
    logic [31:0] period;
  } path_cmd_t;

  // One result transaction. The fields are four-state so that X on a port is caught.
  typedef struct {
    status_t     st;
    logic        pos_valid;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        strobe;
    logic        run;
    adc_mode_t   mode;
    logic        fb_off;
  } player_out_t;

  // Tracks the slot pool, the play queue and the playback timer, and holds the
  // outputs that each accepted command should produce, oldest first.
  class playback_ledger;
    bit          slot_busy[SLOTS];
    bit [8:0]    slot_fill[SLOTS];
    bit [47:0]   point_mem[SLOTS * PTS];
    bit [2:0]    order_slot[SLOTS];
    bit [2:0]    order_head;
    bit [3:0]    order_count;
    bit          loading;
    bit [2:0]    load_slot;
    bit [8:0]    load_len;
    bit          playing;
    bit [8:0]    play_idx;
    bit [31:0]   tick_count;
    bit [31:0]   tick_period;
    adc_mode_t   mode;
    player_out_t awaited[$];
    int          live_items;
    int          faults;

    function new();
      tick_period = 1;
      mode = MODE_OFF;
    endfunction

    function void vacate_slot(bit [2:0] s);
      slot_busy[s] = 1'b0;
      slot_fill[s] = '0;
    endfunction

    // A path whose last point has arrived joins the tail of the play queue.
    function void close_if_full();
      bit [2:0] tail;
      if (slot_fill[load_slot] >= load_len) begin
        if (order_count < SLOTS) begin
          tail = order_head + order_count[2:0];
          order_slot[tail] = load_slot;
          order_count++;
        end
        loading = 1'b0;
      end
    endfunction

    function status_t load_point(path_cmd_t c);
      bit [3:0] s;
      if (c.idx == 0) begin
        // A new first point abandons any load in progress before anything else.
        if (loading) begin
          vacate_slot(load_slot);
          loading = 1'b0;
        end
        if (c.len > PTS) return ST_TOO_LONG;
        if (c.len == 0) return ST_EMPTY;
        s = 0;
        while (s < SLOTS && slot_busy[s]) s++;
        if (s == SLOTS) return ST_NO_SLOT;
        slot_busy[s] = 1'b1;
        load_slot = s[2:0];
        load_len = c.len[8:0];
        loading = 1'b1;
        point_mem[int'(s) * PTS] = {c.z, c.y, c.x};
        slot_fill[s] = 9'd1;
        close_if_full();
        return ST_OK;
      end
      if (!loading || c.idx != 16'(slot_fill[load_slot])) return ST_BAD_SEQ;
      point_mem[int'(load_slot) * PTS + int'(c.idx)] = {c.z, c.y, c.x};
      slot_fill[load_slot] = c.idx[8:0] + 9'd1;
      close_if_full();
      return ST_OK;
    endfunction

    function player_out_t advance(path_cmd_t c);
      player_out_t r;
      bit [2:0]    s;
      bit [47:0]   p;
      r.st = ST_OK;
      r.pos_valid = 1'b0;
      r.strobe = 1'b0;
      r.fb_off = 1'b0;
      p = '0;
      case (c.kind)
        K_LOAD: r.st = load_point(c);
        K_START: begin
          if (playing) begin
            r.st = ST_RUNNING;
          end else if (order_count == 0) begin
            r.st = ST_NOTHING;
          end else begin
            r.fb_off = 1'b1;
            mode = c.sync ? MODE_MANUAL : MODE_AUTO;
            play_idx = '0;
            playing = 1'b1;
            tick_period = (c.period == 0) ? 32'd1 : c.period;
            tick_count = '0;
          end
        end
        K_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) vacate_slot(3'(i));
          order_head = '0;
          order_count = '0;
          loading = 1'b0;
          playing = 1'b0;
          play_idx = '0;
          tick_count = '0;
          mode = MODE_OFF;
        end
        default: begin
          if (playing) begin
            tick_count++;
            if (tick_count >= tick_period) begin
              tick_count = '0;
              // A finished head path is retired first; the next one then plays
              // its first point within the same period.
              s = order_slot[order_head];
              if (order_count > 0 && play_idx >= slot_fill[s]) begin
                vacate_slot(s);
                order_head++;
                order_count--;
                play_idx = '0;
              end
              if (order_count == 0) begin
                playing = 1'b0;
                mode = MODE_OFF;
              end else begin
                s = order_slot[order_head];
                if (play_idx < PTS) p = point_mem[int'(s) * PTS + int'(play_idx)];
                r.pos_valid = 1'b1;
                r.strobe = 1'b1;
                play_idx++;
              end
            end
          end
        end
      endcase
      r.x = p[15:0];
      r.y = p[31:16];
      r.z = p[47:32];
      r.run = playing;
      r.mode = mode;
      return r;
    endfunction

    function void note_command(path_cmd_t c);
      live_items++;
      awaited.push_back(advance(c));
    endfunction

    function string fmt(player_out_t r);
      return $sformatf("st=%0d pv=%0b x=%h y=%h z=%h strobe=%0b run=%0b mode=%0d fb=%0b",
                       r.st, r.pos_valid, r.x, r.y, r.z, r.strobe, r.run, r.mode, r.fb_off);
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("%t ERROR %s", $realtime, msg);
    endfunction

    function void check_result(player_out_t got);
      player_out_t want;
      if (awaited.size() == 0) begin
        flag({"result with nothing awaited: ", fmt(got)});
        return;
      end
      want = awaited.pop_front();
      if (got.st !== want.st || got.pos_valid !== want.pos_valid ||
          got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.strobe !== want.strobe || got.run !== want.run ||
          got.mode !== want.mode || got.fb_off !== want.fb_off)
        flag({"mismatch, expected ", fmt(want), " got ", fmt(got)});
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] point_index;
  logic [15:0] path_length;
  logic        manual_trig;
  logic [31:0] period_ticks;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic        position_valid;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_z;
  logic        adc_strobe;
  logic        running;
  logic [1:0]  trigger_mode;
  logic        feedback_disable;

  playback_ledger ledger = new();

  // Chance, in percent per cycle, that the sender holds back a transaction and
  // that the receiver drops ready.
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles = 0;

  waypoint_path_player u_dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Builds a command of the given kind with every other field random, so that
  // the unused fields toggle too.
  function automatic path_cmd_t random_cmd(op_kind_t k);
    path_cmd_t c;
    c.kind = k;
    c.x = 16'($urandom);
    c.y = 16'($urandom);
    c.z = 16'($urandom);
    c.idx = 16'($urandom);
    c.len = 16'($urandom);
    c.sync = 1'($urandom);
    c.period = $urandom;
    return c;
  endfunction

  // Mostly short periods so that playback keeps moving; now and then zero, and
  // rarely a full 32-bit value that parks the player until the next clear.
  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(19);
    if (r < 10) return 32'd1;
    if (r < 16) return 32'($urandom_range(4, 2));
    if (r < 19) return 32'd0;
    return $urandom;
  endfunction

  // Presents one transaction and returns at the edge where it is accepted.
  // Valid is left high on return; the next call decides whether to drop it.
  task automatic push_cmd(input path_cmd_t c);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= c.kind;
    pos_x <= c.x;
    pos_y <= c.y;
    pos_z <= c.z;
    point_index <= c.idx;
    path_length <= c.len;
    manual_trig <= c.sync;
    period_ticks <= c.period;
    do @(posedge clk); while (!in_ready);
    ledger.note_command(c);
  endtask

  task automatic send_load(input int idx, input int len);
    path_cmd_t c;
    c = random_cmd(K_LOAD);
    c.idx = 16'(idx);
    c.len = 16'(len);
    push_cmd(c);
  endtask

  task automatic send_start(input bit sync, input logic [31:0] period);
    path_cmd_t c;
    c = random_cmd(K_START);
    c.sync = sync;
    c.period = period;
    push_cmd(c);
  endtask

  task automatic send_plain(input op_kind_t k);
    push_cmd(random_cmd(k));
  endtask

  // Loads a path of n points in order. A sloppy load may throw in an
  // out-of-order point or stop early, leaving the load open for a later
  // first point to abort. Later points sometimes carry a stray length.
  task automatic load_path(input int n, input bit sloppy);
    path_cmd_t c;
    for (int i = 0; i < n; i++) begin
      if (sloppy && $urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0: send_load(i + 1 + $urandom_range(3), n);
          1: send_load($urandom_range(65535, 1), $urandom_range(65535));
          default: return;
        endcase
      end
      c = random_cmd(K_LOAD);
      c.idx = 16'(i);
      if (i == 0 || $urandom_range(3) != 0) c.len = 16'(n);
      push_cmd(c);
    end
  endtask

  // Stops sending until every awaited result has come back. At least one edge
  // passes, so valid is never dropped and raised in the same time step.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  // Random traffic until the running count of accepted transactions reaches
  // goal. Most of it is well-formed paths, starts and tick bursts so that
  // playback actually walks through queued paths; the rest is noise.
  task automatic random_phase(input int goal, input int gap_pct, input int stall_pct);
    int pick;
    int n;
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    while (ledger.live_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        n = ($urandom_range(15) < 12) ? $urandom_range(4, 1) : $urandom_range(24, 5);
        load_path(n, $urandom_range(9) == 0);
      end else if (pick < 50) begin
        send_start(1'($urandom), pick_period());
      end else if (pick < 85) begin
        repeat ($urandom_range(12, 1)) send_plain(K_TICK);
      end else if (pick < 96) begin
        // Noise: arbitrary index and length, sometimes as a first point so
        // that long and zero lengths are tried against an open load.
        if ($urandom_range(1)) send_load(0, $urandom_range(65535));
        else send_load($urandom_range(65535), $urandom_range(65535));
      end else begin
        send_plain(K_CLEAR);
      end
    end
    hold_until_drained();
  endtask

  // Result side: checks every accepted result and stalls at random.
  initial begin
    player_out_t got;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.st = status_t'(status);
        got.pos_valid = position_valid;
        got.x = out_x;
        got.y = out_y;
        got.z = out_z;
        got.strobe = adc_strobe;
        got.run = running;
        got.mode = adc_mode_t'(trigger_mode);
        got.fb_off = feedback_disable;
        ledger.check_result(got);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Hang detection: any transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    path_cmd_t c;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= K_TICK;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    point_index <= '0;
    path_length <= '0;
    manual_trig <= 1'b0;
    period_ticks <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    sender_gap_pct = 7;
    receiver_stall_pct = 70;

    // Directed part. A tick and a start with nothing loaded, then the rejected
    // first points: zero length, one point too many, and a stray later point.
    send_plain(K_TICK);
    send_start(1'b1, 32'd1);
    send_load(0, 0);
    send_load(0, PTS + 1);
    send_load(5, 1);

    // Path A, three points, all-ones first point. An early third point is
    // refused without closing the load, and the second point carries a
    // length that must be ignored.
    c = random_cmd(K_LOAD);
    c.idx = 16'd0;
    c.len = 16'd3;
    c.x = 16'hFFFF;
    c.y = 16'hFFFF;
    c.z = 16'hFFFF;
    push_cmd(c);
    send_load(2, 3);
    c = random_cmd(K_LOAD);
    c.idx = 16'd1;
    c.len = 16'hFFFF;
    c.x = 16'h0000;
    c.y = 16'h0000;
    c.z = 16'h0000;
    push_cmd(c);
    send_load(2, 3);

    // Path B is begun as a two-point path, then restarted as a one-point path,
    // which frees and reclaims the same slot.
    send_load(0, 2);
    send_load(0, 1);

    // Fill the rest of the pool, then one first point too many.
    repeat (6) send_load(0, 1);
    send_load(0, 1);

    // Manual trigger with a zero period, which must behave as one tick. A
    // second start is refused while running.
    send_start(1'b1, 32'd0);
    send_start(1'b0, 32'd5);

    // Three points of A, then A retires and B plays in the same period.
    repeat (4) send_plain(K_TICK);

    // Clear while paths are still queued stops playback.
    send_plain(K_CLEAR);
    hold_until_drained();

    // Random part, three idling patterns. The middle one begins with a
    // full-length path on an empty pool so the deepest store addresses get
    // played back.
    random_phase(250, 7, 70);
    sender_gap_pct = 70;
    receiver_stall_pct = 7;
    send_plain(K_CLEAR);
    load_path(PTS, 1'b0);
    random_phase(650, 70, 7);
    random_phase(800, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.faults == 0 && ledger.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
